// File: rtl/core/capa_pkg.sv
// ----------------------------------------------------------------------------
// capa_pkg
// Shared constants, codes and the rule-150 word function for the
// cellular automaton privacy amplifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package capa_pkg;

  // datapath word and register widths
  localparam int WORD_W       = 64;
  localparam int RING_LEN_W   = 13;
  localparam int BPG_W        = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // default ring storage in bits
  localparam int RING_BITS_DEF = 256;

  // register reset values
  localparam logic [RING_LEN_W-1:0] RING_LEN_RST = 13'd256;
  localparam logic [BPG_W-1:0]      BPG_RST      = 16'd1;

  // register index, taken from paddr bit 2
  localparam logic REG_RING_LEN = 1'b0;
  localparam logic REG_BPG      = 1'b1;

  // input opcodes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // ones from bit 0 up to and including bit top
  function automatic logic [WORD_W-1:0] top_mask(input logic [5:0] top);
    return {WORD_W{1'b1}} >> (6'd63 - top);
  endfunction

  // one ring word of the rule-150 step: left ^ centre ^ right
  // lbit feeds bit 0 from the left, rbit enters at bit top from the right
  function automatic logic [WORD_W-1:0] rule150_word(
    input logic [WORD_W-1:0] cur,
    input logic              lbit,
    input logic              rbit,
    input logic [5:0]        top,
    input logic [WORD_W-1:0] mask
  );
    logic [WORD_W-1:0] left_n;
    logic [WORD_W-1:0] right_n;
    logic [WORD_W-1:0] top_sel;
    left_n  = {cur[WORD_W-2:0], lbit};
    top_sel = {{(WORD_W-1){1'b0}}, 1'b1} << top;
    right_n = (cur >> 1) | (rbit ? top_sel : '0);
    return (left_n ^ cur ^ right_n) & mask;
  endfunction

endpackage

// File: rtl/core/capa_ram.sv
// ----------------------------------------------------------------------------
// capa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ca_rule150_privacy_amplifier_core.sv
// ----------------------------------------------------------------------------
// ca_rule150_privacy_amplifier_core
// Key compression with a circular rule-150 cellular automaton ring.
// ----------------------------------------------------------------------------
// Usage
//   Input beats carry opcode (seed or key) and a 64-bit data_word. Seed beats
//   load the ring word by word and clear the accumulator. Key beats are ANDed
//   with the ring and folded into the accumulator; each completed block of
//   ring_len bits steps the ring once. After blocks_per_group blocks the
//   accumulator goes out as ceil(L/64) hash_word beats, last_word on the final
//   one, and is then loaded into the ring and stepped once more.
//   Sequencing: a seed beat is written from the idle state, a key beat passes
//   through an accumulate state. A ring step walks the ring RAM one word a
//   cycle through the single rule-150 word unit. Each output word passes a
//   read, an output and a wait state, the last held while the receiver holds
//   out_stall. in_stall is high whenever the sequencer is busy, so only one
//   item is in flight. A configuration write masks the ring and accumulator
//   to the new length in a read and a write state, with in_stall high.
//   Reset is synchronous; ring and accumulator read as zero through per-word
//   valid bits, so there is no clearing pass. A stalled output beat holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ca_rule150_privacy_amplifier_core #(
  parameter int RING_BITS = capa_pkg::RING_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [capa_pkg::WORD_W-1:0]      data_word,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [capa_pkg::WORD_W-1:0]      hash_word,
  output logic                             last_word,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [capa_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [capa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [capa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int WW         = capa_pkg::WORD_W;
  localparam int RING_WORDS = (RING_BITS + WW - 1) / WW;
  localparam int WIDX       = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;
  localparam int NW_W       = $clog2(RING_WORDS + 1);
  localparam int SC_W       = $clog2(RING_WORDS + 3);
  localparam int LEN_W      = $clog2(RING_BITS + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_KEY_ACC   = 3'd1;
  localparam logic [2:0] ST_STEP      = 3'd2;
  localparam logic [2:0] ST_EMIT_RD   = 3'd3;
  localparam logic [2:0] ST_EMIT_OUT  = 3'd4;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd5;
  localparam logic [2:0] ST_CFG_RD    = 3'd6;
  localparam logic [2:0] ST_CFG_WR    = 3'd7;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [capa_pkg::RING_LEN_W-1:0]  ring_len;
  logic [capa_pkg::BPG_W-1:0]       bpg;
  logic [WIDX-1:0]                  word_pos;
  logic [capa_pkg::BPG_W-1:0]       block_pos;
  logic                             edge_op;
  logic [RING_WORDS-1:0]            ca_valid;
  logic [RING_WORDS-1:0]            ca_valid_next;
  logic [RING_WORDS-1:0]            acc_valid;
  logic [RING_WORDS-1:0]            acc_valid_next;
  logic [SC_W-1:0]                  scnt;
  logic [WIDX-1:0]                  wcnt;
  logic                             group_pend;

  // datapath registers
  logic [WW-1:0]                    key_data;
  logic [WW-1:0]                    cur_word;
  logic                             left_bit;
  logic                             w0_bit;
  logic                             prev_bit;
  logic                             ca_vld_q;
  logic                             acc_vld_q;

  // ram ports
  logic [WIDX-1:0]                  raddr;
  logic                             ca_we;
  logic [WIDX-1:0]                  ca_waddr;
  logic [WW-1:0]                    ca_wdata;
  logic [WW-1:0]                    ca_rdata;
  logic                             acc_we;
  logic [WIDX-1:0]                  acc_waddr;
  logic [WW-1:0]                    acc_wdata;
  logic [WW-1:0]                    acc_rdata;
  logic [WW-1:0]                    ca_rd_word;
  logic [WW-1:0]                    acc_rd_word;

  // derived ring geometry
  logic [capa_pkg::RING_LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]                 eff_len;
  logic [LEN_W-1:0]                 len_m1;
  logic [WIDX-1:0]                  last_w;
  logic [5:0]                       top_bit;
  logic [NW_W-1:0]                  nw;
  logic [RING_WORDS-1:0]            in_ring;

  logic                             in_beat;
  logic                             out_beat;
  logic                             cfg_beat;
  logic [WIDX-1:0]                  wp_eff;
  logic [capa_pkg::BPG_W-1:0]       bp_inc;
  logic [capa_pkg::BPG_W-1:0]       bpg_eff;
  logic                             grp_done;
  logic                             step_end;
  logic [WIDX-1:0]                  step_waddr;
  logic                             step_rbit;
  logic [5:0]                       step_top;

  // mask of the valid cells of ring word w under the current length
  function automatic logic [WW-1:0] word_mask(input logic [WIDX-1:0] w,
                                              input logic [WIDX-1:0] lw,
                                              input logic [5:0]      tb);
    logic [WW-1:0] m;
    if (w < lw) begin
      m = '1;
    end else if (w == lw) begin
      m = capa_pkg::top_mask(tb);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  // storage for the ring and the accumulator
  capa_ram #(.WIDTH(WW), .DEPTH(RING_WORDS)) u_ca_ram (
    .clk   (clk),
    .we    (ca_we),
    .waddr (ca_waddr),
    .wdata (ca_wdata),
    .raddr (raddr),
    .rdata (ca_rdata)
  );

  capa_ram #(.WIDTH(WW), .DEPTH(RING_WORDS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (raddr),
    .rdata (acc_rdata)
  );

  // handshakes
  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign pready   = 1'b1;
  assign cfg_beat = psel && penable && pwrite && pready;

  // register read back
  always_comb begin
    unique case (paddr[2])
      capa_pkg::REG_RING_LEN: prdata = capa_pkg::APB_DATA_W'(ring_len);
      capa_pkg::REG_BPG:      prdata = capa_pkg::APB_DATA_W'(bpg);
      default:                prdata = '0;
    endcase
  end

  // effective length clamped to at least 2 and at most the ring storage
  always_comb begin
    if (ring_len < capa_pkg::RING_LEN_W'(2)) begin
      len_sat = capa_pkg::RING_LEN_W'(2);
    end else if (ring_len > capa_pkg::RING_LEN_W'(RING_BITS)) begin
      len_sat = capa_pkg::RING_LEN_W'(RING_BITS);
    end else begin
      len_sat = ring_len;
    end
  end

  assign eff_len = LEN_W'(len_sat);
  assign len_m1  = eff_len - LEN_W'(1);
  assign last_w  = WIDX'(len_m1 >> 6);
  assign top_bit = len_m1[5:0];
  assign nw      = NW_W'(len_m1 >> 6) + NW_W'(1);

  always_comb begin
    for (int w = 0; w < RING_WORDS; w++) begin
      in_ring[w] = (WIDX'(w) <= last_w);
    end
  end

  // invalid words read as zero
  assign ca_rd_word  = ca_vld_q  ? ca_rdata  : '0;
  assign acc_rd_word = acc_vld_q ? acc_rdata : '0;

  // item bookkeeping
  assign wp_eff   = ((opcode != edge_op) || (word_pos > last_w)) ? '0 : word_pos;
  assign bpg_eff  = (bpg == '0) ? capa_pkg::BPG_W'(1) : bpg;
  assign bp_inc   = block_pos + capa_pkg::BPG_W'(1);
  assign grp_done = (bp_inc >= bpg_eff);

  // ring step walk: pre-read last word, then words 0..nw-1, write two words behind the read
  assign step_end   = (scnt == SC_W'(nw) + SC_W'(2));
  assign step_waddr = WIDX'(scnt - SC_W'(3));
  assign step_rbit  = step_end ? w0_bit : ca_rd_word[0];
  assign step_top   = (step_waddr == last_w) ? top_bit : 6'd63;

  // sequencer and ram port control
  always_comb begin
    raddr      = '0;
    ca_we      = 1'b0;
    ca_waddr   = '0;
    ca_wdata   = '0;
    acc_we     = 1'b0;
    acc_waddr  = '0;
    acc_wdata  = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        raddr = wp_eff;
        if (in_beat) begin
          if (opcode == capa_pkg::OP_SEED) begin
            ca_we    = 1'b1;
            ca_waddr = wp_eff;
            ca_wdata = data_word & word_mask(wp_eff, last_w, top_bit);
          end else begin
            state_next = ST_KEY_ACC;
          end
        end
      end
      ST_KEY_ACC: begin
        acc_we    = 1'b1;
        acc_waddr = wcnt;
        acc_wdata = acc_rd_word ^ (key_data & ca_rd_word & word_mask(wcnt, last_w, top_bit));
        state_next = (wcnt == last_w) ? ST_STEP : ST_IDLE;
      end
      ST_STEP: begin
        if (scnt == '0) begin
          raddr = last_w;
        end else if ((scnt - SC_W'(1)) <= SC_W'(last_w)) begin
          raddr = WIDX'(scnt - SC_W'(1));
        end
        if (scnt >= SC_W'(3)) begin
          ca_we    = 1'b1;
          ca_waddr = step_waddr;
          ca_wdata = capa_pkg::rule150_word(cur_word, prev_bit, step_rbit, step_top,
                                            word_mask(step_waddr, last_w, top_bit));
        end
        if (step_end) begin
          state_next = group_pend ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        raddr      = wcnt;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        ca_we      = 1'b1;
        ca_waddr   = wcnt;
        ca_wdata   = acc_rd_word;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_beat) begin
          state_next = last_word ? ST_STEP : ST_EMIT_RD;
        end
      end
      ST_CFG_RD: begin
        raddr      = last_w;
        state_next = ST_CFG_WR;
      end
      ST_CFG_WR: begin
        ca_we      = 1'b1;
        ca_waddr   = last_w;
        ca_wdata   = ca_rd_word & word_mask(last_w, last_w, top_bit);
        acc_we     = 1'b1;
        acc_waddr  = last_w;
        acc_wdata  = acc_rd_word & word_mask(last_w, last_w, top_bit);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cfg_beat) begin
      state_next = ST_CFG_RD;
    end
  end

  // word valid bits: set on write, cleared by seed, step end and length change
  always_comb begin
    ca_valid_next  = ca_valid;
    acc_valid_next = acc_valid;
    if (ca_we) begin
      ca_valid_next[ca_waddr] = 1'b1;
    end
    if (acc_we) begin
      acc_valid_next[acc_waddr] = 1'b1;
    end
    if ((state == ST_STEP) && step_end) begin
      ca_valid_next = ca_valid_next & in_ring;
    end
    if (state == ST_CFG_RD) begin
      ca_valid_next  = ca_valid_next & in_ring;
      acc_valid_next = acc_valid_next & in_ring;
    end
    if (in_beat && (opcode == capa_pkg::OP_SEED)) begin
      acc_valid_next = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_len   <= capa_pkg::RING_LEN_RST;
      bpg        <= capa_pkg::BPG_RST;
      word_pos   <= '0;
      block_pos  <= '0;
      edge_op    <= 1'b0;
      ca_valid   <= '0;
      acc_valid  <= '0;
      scnt       <= '0;
      wcnt       <= '0;
      group_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      ca_valid  <= ca_valid_next;
      acc_valid <= acc_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            edge_op <= opcode;
            wcnt    <= wp_eff;
            if (opcode == capa_pkg::OP_SEED) begin
              block_pos <= '0;
              word_pos  <= (wp_eff == last_w) ? '0 : wp_eff + WIDX'(1);
            end
          end
        end
        ST_KEY_ACC: begin
          if (wcnt == last_w) begin
            word_pos   <= '0;
            block_pos  <= grp_done ? '0 : bp_inc;
            group_pend <= grp_done;
            scnt       <= '0;
          end else begin
            word_pos <= wcnt + WIDX'(1);
          end
        end
        ST_STEP: begin
          if (step_end) begin
            scnt       <= '0;
            wcnt       <= '0;
            group_pend <= 1'b0;
          end else begin
            scnt <= scnt + SC_W'(1);
          end
        end
        ST_EMIT_RD: begin
        end
        ST_EMIT_OUT: begin
          out_valid <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_beat) begin
            out_valid <= 1'b0;
            wcnt      <= wcnt + WIDX'(1);
            scnt      <= '0;
          end
        end
        ST_CFG_RD: begin
        end
        ST_CFG_WR: begin
        end
        default: begin
        end
      endcase
      // register writes restart word and block counting
      if (cfg_beat) begin
        unique case (paddr[2])
          capa_pkg::REG_RING_LEN: ring_len <= pwdata[capa_pkg::RING_LEN_W-1:0];
          capa_pkg::REG_BPG:      bpg      <= pwdata[capa_pkg::BPG_W-1:0];
          default:                ;
        endcase
        word_pos  <= '0;
        block_pos <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ca_vld_q  <= ca_valid[raddr];
    acc_vld_q <= acc_valid[raddr];
    if (in_beat) begin
      key_data <= data_word;
    end
    // step walk: neighbor bits and the word being rewritten
    if (state == ST_STEP) begin
      if (scnt == SC_W'(1)) begin
        left_bit <= ca_rd_word[top_bit];
      end else if (scnt == SC_W'(2)) begin
        cur_word <= ca_rd_word;
        w0_bit   <= ca_rd_word[0];
        prev_bit <= left_bit;
      end else if (scnt >= SC_W'(3)) begin
        prev_bit <= cur_word[WW-1];
        cur_word <= ca_rd_word;
      end
    end
    // output beat register
    if (state == ST_EMIT_OUT) begin
      hash_word <= acc_rd_word;
      last_word <= (wcnt == last_w);
    end
  end

  // output beats only come from the emit wait state
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_EMIT_WAIT))
    else $error("output beat outside emit");

  // a group's final word is followed by the ring step
  a_last_then_step: assert property (@(posedge clk) disable iff (rst)
    (out_beat && last_word && !cfg_beat) |=> (state == ST_STEP))
    else $error("no ring step after last word");

  // step walk never runs past the ring end
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (scnt <= SC_W'(nw) + SC_W'(2)))
    else $error("step counter past ring end");

  // accumulator words beyond the ring are never live
  a_acc_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CFG_RD) |-> ((acc_valid & ~in_ring) == '0))
    else $error("accumulator word beyond ring is valid");

endmodule
